// ===== rtl/ffpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared codes and types of the first-fit pool allocator: commands, status
// codes, register indexes, cell operations and the cell flag group.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  // request codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  // configuration register indexes
  localparam logic REG_BASE = 1'b0;
  localparam logic REG_POOL = 1'b1;

  // operations broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INIT,
    OP_START,
    OP_STEP,
    OP_GRANT,
    OP_RELEASE,
    OP_MERGE_NEXT,
    OP_MERGE_PREV
  } ffpa_op_t;

  // command to the chain
  typedef struct packed {
    ffpa_op_t    op;
    logic        split;
    logic [15:0] size;
  } ffpa_cmd_t;

  // conditions seen at the token cell
  typedef struct packed {
    logic fit;
    logic split;
    logic match;
    logic used;
    logic has_next;
    logic next_free;
    logic prev_free;
  } ffpa_flags_t;

endpackage

// ===== rtl/ffpa_cell.sv =====
// ----------------------------------------------------------------------------
// ffpa_cell
// One block of the address-ordered table. Holds start, end and used flag,
// plus the search token; shifts with its neighbours on insert and merge.
// ----------------------------------------------------------------------------
module ffpa_cell import ffpa_pkg::*; #(
  parameter int OFS_W          = 17,
  parameter int HEADER_BYTES   = 20,
  parameter int POOL_MAX_BYTES = 65536,
  parameter bit IS_FIRST       = 1'b0
) (
  input  logic             clk,
  input  logic             rst,
  input  ffpa_cmd_t        cmd,
  input  logic [OFS_W-1:0] off,
  input  logic [OFS_W-1:0] pool,
  input  logic             left_v,
  input  logic             left_u,
  input  logic             left_t,
  input  logic [OFS_W-1:0] left_s,
  input  logic [OFS_W-1:0] left_e,
  input  logic             right_v,
  input  logic             right_u,
  input  logic             right_t,
  input  logic [OFS_W-1:0] right_s,
  input  logic [OFS_W-1:0] right_e,
  output logic             v,
  output logic             u,
  output logic             t,
  output logic [OFS_W-1:0] s,
  output logic [OFS_W-1:0] e,
  output logic [OFS_W-1:0] tok_s,
  output ffpa_flags_t      flags
);

  localparam int CW = ((OFS_W > 16) ? OFS_W : 16) + 1;

  logic             vis;
  logic             v_next, u_next, t_next, vis_next;
  logic [OFS_W-1:0] s_next, e_next;
  logic [CW-1:0]    pay;
  logic             fit, split_ok;

  // local size checks
  assign pay      = CW'(e) - CW'(s);
  assign fit      = v && !u && (pay > CW'(cmd.size));
  assign split_ok = (pay - CW'(cmd.size)) > CW'(2 * HEADER_BYTES);

  assign tok_s = t ? s : '0;

  always_comb begin
    flags.fit       = t && fit;
    flags.split     = t && fit && split_ok;
    flags.match     = t && v && (s == off);
    flags.used      = t && u;
    flags.has_next  = t && right_v;
    flags.next_free = t && right_v && !right_u;
    flags.prev_free = t && left_v && !left_u;
  end

  // next cell contents
  always_comb begin
    v_next   = v;
    u_next   = u;
    t_next   = t;
    vis_next = vis;
    s_next   = s;
    e_next   = e;
    case (cmd.op)
      OP_INIT: begin
        v_next   = IS_FIRST;
        u_next   = 1'b0;
        t_next   = 1'b0;
        vis_next = 1'b0;
        s_next   = OFS_W'(HEADER_BYTES);
        e_next   = pool;
      end
      OP_START: begin
        t_next   = IS_FIRST;
        vis_next = IS_FIRST;
      end
      OP_STEP: begin
        t_next   = left_t;
        vis_next = vis || left_t;
      end
      OP_GRANT: begin
        if (t) begin
          u_next = 1'b1;
          if (cmd.split) begin
            e_next = OFS_W'(CW'(s) + CW'(cmd.size));
          end
        end else if (cmd.split && left_t) begin
          v_next = 1'b1;
          u_next = 1'b0;
          s_next = OFS_W'(CW'(left_s) + CW'(cmd.size) + CW'(HEADER_BYTES));
          e_next = left_e;
        end else if (cmd.split && !vis) begin
          v_next = left_v;
          u_next = left_u;
          s_next = left_s;
          e_next = left_e;
        end
      end
      OP_RELEASE: begin
        if (t) begin
          u_next = 1'b0;
        end
      end
      OP_MERGE_NEXT: begin
        if (t) begin
          e_next = right_e;
        end else if (!vis) begin
          v_next = right_v;
          u_next = right_u;
          s_next = right_s;
          e_next = right_e;
        end
      end
      OP_MERGE_PREV: begin
        if (right_t) begin
          e_next = right_e;
        end else if (t || !vis) begin
          v_next = right_v;
          u_next = right_u;
          s_next = right_s;
          e_next = right_e;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v   <= IS_FIRST;
      u   <= 1'b0;
      t   <= 1'b0;
      vis <= 1'b0;
      s   <= OFS_W'(HEADER_BYTES);
      e   <= OFS_W'(POOL_MAX_BYTES);
    end else begin
      v   <= v_next;
      u   <= u_next;
      t   <= t_next;
      vis <= vis_next;
      s   <= s_next;
      e   <= e_next;
    end
  end

endmodule

// ===== rtl/first_fit_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_pool_allocator
// First-fit allocator with coalescing over one pool, table kept in a chain
// of cells in address order.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel in_valid/in_stall carries cmd, req_size and free_addr;
//    a transfer takes place when in_valid is high and in_stall is low
//  - output channel out_valid/out_stall carries status and alloc_addr,
//    one result per request, in request order
//  - a search token walks the cell chain one cell per cycle, so an
//    allocate or a free takes longer the further along the chain the
//    block reached lies (at most position MAX_BLOCKS - 1)
//  - in_stall stays high while a request is in flight; a finished result
//    sits in the output register, so if out_stall holds it there the next
//    request still runs and waits only to hand over its result
//  - cfg_we writes base_address (index 0) or pool_bytes (index 1) while
//    idle; either write then rebuilds the table in the init state
//  - rst (synchronous) empties the table to one free block over the pool
// ----------------------------------------------------------------------------
module first_fit_pool_allocator import ffpa_pkg::*; #(
  parameter int POOL_MAX_BYTES = 65536,
  parameter int HEADER_BYTES   = 20,
  parameter int MAX_BLOCKS     = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [15:0] req_size,
  input  logic [31:0] free_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] alloc_addr
);

  localparam int OFS_W = $clog2(POOL_MAX_BYTES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_ASRCH, S_FSRCH, S_FMN, S_FMP, S_FIN
  } state_t;

  state_t           state;
  logic [31:0]      base;
  logic [OFS_W-1:0] pool;
  logic [15:0]      size_q;
  logic [OFS_W-1:0] off_q;
  logic [1:0]       res_status;
  logic [31:0]      res_addr;

  ffpa_cmd_t        chain_cmd;
  ffpa_flags_t      flags_any;
  logic [OFS_W-1:0] tok_s_any;

  logic             cell_v [MAX_BLOCKS];
  logic             cell_u [MAX_BLOCKS];
  logic             cell_t [MAX_BLOCKS];
  logic [OFS_W-1:0] cell_s [MAX_BLOCKS];
  logic [OFS_W-1:0] cell_e [MAX_BLOCKS];
  logic [OFS_W-1:0] cell_ts [MAX_BLOCKS];
  ffpa_flags_t      cell_f [MAX_BLOCKS];

  logic             in_xfer;
  logic [31:0]      in_off;
  logic             in_bad;
  logic             out_free;
  logic [OFS_W-1:0] pool_sat;

  assign in_stall = (state != S_IDLE) || cfg_we;
  assign in_xfer  = in_valid && !in_stall;
  assign in_off   = free_addr - base;
  assign in_bad   = (in_off < 32'(HEADER_BYTES)) || (in_off >= 32'(pool));
  assign out_free = !out_valid || !out_stall;

  // saturate the pool size into its legal range
  always_comb begin
    if (cfg_wdata < 32'(HEADER_BYTES + 1)) begin
      pool_sat = OFS_W'(HEADER_BYTES + 1);
    end else if (cfg_wdata > 32'(POOL_MAX_BYTES)) begin
      pool_sat = OFS_W'(POOL_MAX_BYTES);
    end else begin
      pool_sat = OFS_W'(cfg_wdata);
    end
  end

  // gather token cell conditions
  always_comb begin
    flags_any = '0;
    tok_s_any = '0;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      flags_any = flags_any | cell_f[i];
      tok_s_any = tok_s_any | cell_ts[i];
    end
  end

  // operation for the chain
  always_comb begin
    chain_cmd.op    = OP_HOLD;
    chain_cmd.split = flags_any.split && !cell_v[MAX_BLOCKS-1];
    chain_cmd.size  = size_q;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          chain_cmd.op = OP_START;
        end
      end
      S_INIT: chain_cmd.op = OP_INIT;
      S_ASRCH: begin
        if (flags_any.fit) begin
          chain_cmd.op = OP_GRANT;
        end else if (flags_any.has_next) begin
          chain_cmd.op = OP_STEP;
        end
      end
      S_FSRCH: begin
        if (flags_any.match) begin
          if (flags_any.used) begin
            chain_cmd.op = OP_RELEASE;
          end
        end else if (flags_any.has_next) begin
          chain_cmd.op = OP_STEP;
        end
      end
      S_FMN: begin
        if (flags_any.next_free) begin
          chain_cmd.op = OP_MERGE_NEXT;
        end
      end
      S_FMP: begin
        if (flags_any.prev_free) begin
          chain_cmd.op = OP_MERGE_PREV;
        end
      end
      default: chain_cmd.op = OP_HOLD;
    endcase
  end

  // chain of block cells
  for (genvar gi = 0; gi < MAX_BLOCKS; gi++) begin : g_cell
    logic             lv, lu, lt, rv, ru, rt;
    logic [OFS_W-1:0] ls, le, rs, re;
    if (gi == 0) begin : g_left0
      assign lv = 1'b0;
      assign lu = 1'b0;
      assign lt = 1'b0;
      assign ls = '0;
      assign le = '0;
    end else begin : g_left
      assign lv = cell_v[gi-1];
      assign lu = cell_u[gi-1];
      assign lt = cell_t[gi-1];
      assign ls = cell_s[gi-1];
      assign le = cell_e[gi-1];
    end
    if (gi == MAX_BLOCKS - 1) begin : g_rightn
      assign rv = 1'b0;
      assign ru = 1'b0;
      assign rt = 1'b0;
      assign rs = '0;
      assign re = '0;
    end else begin : g_right
      assign rv = cell_v[gi+1];
      assign ru = cell_u[gi+1];
      assign rt = cell_t[gi+1];
      assign rs = cell_s[gi+1];
      assign re = cell_e[gi+1];
    end
    ffpa_cell #(
      .OFS_W          (OFS_W),
      .HEADER_BYTES   (HEADER_BYTES),
      .POOL_MAX_BYTES (POOL_MAX_BYTES),
      .IS_FIRST       (gi == 0)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (chain_cmd),
      .off     (off_q),
      .pool    (pool),
      .left_v  (lv),
      .left_u  (lu),
      .left_t  (lt),
      .left_s  (ls),
      .left_e  (le),
      .right_v (rv),
      .right_u (ru),
      .right_t (rt),
      .right_s (rs),
      .right_e (re),
      .v       (cell_v[gi]),
      .u       (cell_u[gi]),
      .t       (cell_t[gi]),
      .s       (cell_s[gi]),
      .e       (cell_e[gi]),
      .tok_s   (cell_ts[gi]),
      .flags   (cell_f[gi])
    );
  end

  // sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      base      <= '0;
      pool      <= OFS_W'(POOL_MAX_BYTES);
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cfg_we) begin
            if (cfg_index == REG_BASE) begin
              base <= cfg_wdata;
            end else begin
              pool <= pool_sat;
            end
            state <= S_INIT;
          end else if (in_xfer) begin
            size_q   <= req_size;
            off_q    <= OFS_W'(in_off);
            res_addr <= '0;
            if (cmd == CMD_ALLOC) begin
              state <= S_ASRCH;
            end else if (in_bad) begin
              res_status <= ST_BADFREE;
              state      <= S_FIN;
            end else begin
              state <= S_FSRCH;
            end
          end
        end
        S_INIT: state <= S_IDLE;
        S_ASRCH: begin
          if (flags_any.fit) begin
            res_status <= ST_OK;
            res_addr   <= base + 32'(tok_s_any);
            state      <= S_FIN;
          end else if (!flags_any.has_next) begin
            res_status <= ST_NOFIT;
            state      <= S_FIN;
          end
        end
        S_FSRCH: begin
          if (flags_any.match) begin
            if (flags_any.used) begin
              state <= S_FMN;
            end else begin
              res_status <= ST_BADFREE;
              state      <= S_FIN;
            end
          end else if (!flags_any.has_next) begin
            res_status <= ST_BADFREE;
            state      <= S_FIN;
          end
        end
        S_FMN: state <= S_FMP;
        S_FMP: begin
          res_status <= ST_OK;
          state      <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            status     <= res_status;
            alloc_addr <= res_addr;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/ffpa_checker.sv =====
// ----------------------------------------------------------------------------
// ffpa_port_checker
// Port-level checks of the pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffpa_port_checker import ffpa_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [31:0] alloc_addr
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(alloc_addr))
    else $error("result changed while stalled");

  // only three status codes exist
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_NOFIT || status == ST_BADFREE))
    else $error("status code out of range");

  // an address is granted only on success
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> alloc_addr == 32'd0)
    else $error("address on a failed request");

  // one request in flight: stall right after a transfer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

endmodule

bind first_fit_pool_allocator ffpa_port_checker u_ffpa_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .alloc_addr (alloc_addr)
);

// ===== tb/ffpa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_checker
// Watches the configuration port and both channels of the first-fit pool
// allocator, keeps its own copy of the block table, predicts the result of
// every accepted request and compares each returned result field by field.
// ----------------------------------------------------------------------------
module ffpa_checker import ffpa_pkg::*; #(
  parameter int POOL_MAX_BYTES = 65536,
  parameter int HEADER_BYTES   = 20,
  parameter int MAX_BLOCKS     = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        cmd,
  input  logic [15:0] req_size,
  input  logic [31:0] free_addr,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic [31:0] alloc_addr,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] addr;
  } grant_t;

  grant_t      grant_q[$];

  // shadow block table
  logic [31:0] blk_start [MAX_BLOCKS];
  logic [31:0] blk_end   [MAX_BLOCKS];
  int          blk_next  [MAX_BLOCKS];
  int          blk_prev  [MAX_BLOCKS];
  bit          blk_used  [MAX_BLOCKS];
  bit          slot_busy [MAX_BLOCKS];
  logic [31:0] pool_base;
  logic [31:0] pool_size;

  function automatic void rebuild_table();
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      blk_start[i] = '0;
      blk_end[i]   = '0;
      blk_next[i]  = 0;
      blk_prev[i]  = 0;
      blk_used[i]  = 1'b0;
      slot_busy[i] = 1'b0;
    end
    blk_start[0] = HEADER_BYTES;
    blk_end[0]   = pool_size;
    slot_busy[0] = 1'b1;
  endfunction

  // lowest spare slot above zero, zero when the table is full
  function automatic int spare_slot();
    for (int i = 1; i < MAX_BLOCKS; i++)
      if (!slot_busy[i]) return i;
    return 0;
  endfunction

  // first-fit search with split of the leftover
  function automatic logic [1:0] grant_block(input logic [15:0] sz,
                                             output logic [31:0] addr);
    int          cur;
    int          s;
    logic [31:0] room;
    cur  = 0;
    addr = '0;
    for (int n = 0; n < MAX_BLOCKS; n++) begin
      room = blk_end[cur] - blk_start[cur];
      if (!blk_used[cur] && room > {16'd0, sz}) begin
        blk_used[cur] = 1'b1;
        if (room - {16'd0, sz} > 2 * HEADER_BYTES) begin
          s = spare_slot();
          if (s != 0) begin
            blk_used[s]  = 1'b0;
            blk_start[s] = blk_start[cur] + sz + HEADER_BYTES;
            blk_end[s]   = blk_end[cur];
            blk_prev[s]  = cur;
            blk_next[s]  = blk_next[cur];
            if (blk_next[cur] != 0) blk_prev[blk_next[cur]] = s;
            blk_next[cur]  = s;
            blk_end[cur]   = blk_start[cur] + sz;
            slot_busy[s]   = 1'b1;
          end
        end
        addr = pool_base + blk_start[cur];
        return ST_OK;
      end
      if (blk_next[cur] == 0) break;
      cur = blk_next[cur];
    end
    return ST_NOFIT;
  endfunction

  // release with merge into free neighbours
  function automatic logic [1:0] release_block(input logic [31:0] a);
    logic [31:0] off;
    int          cur;
    int          nx;
    int          pv;
    bit          hit;
    off = a - pool_base;
    cur = 0;
    hit = 1'b0;
    if (off < HEADER_BYTES || off >= pool_size) return ST_BADFREE;
    for (int n = 0; n < MAX_BLOCKS; n++) begin
      if (blk_start[cur] == off) begin
        hit = 1'b1;
        break;
      end
      if (blk_next[cur] == 0) return ST_BADFREE;
      cur = blk_next[cur];
    end
    if (!hit || !blk_used[cur]) return ST_BADFREE;
    blk_used[cur] = 1'b0;
    nx = blk_next[cur];
    if (nx != 0 && !blk_used[nx]) begin
      blk_end[cur]  = blk_end[nx];
      blk_next[cur] = blk_next[nx];
      if (blk_next[cur] != 0) blk_prev[blk_next[cur]] = cur;
      slot_busy[nx] = 1'b0;
    end
    pv = blk_prev[cur];
    if (cur != 0 && !blk_used[pv]) begin
      blk_end[pv]  = blk_end[cur];
      blk_next[pv] = blk_next[cur];
      if (blk_next[cur] != 0) blk_prev[blk_next[cur]] = pv;
      slot_busy[cur] = 1'b0;
    end
    return ST_OK;
  endfunction

  // follow configuration, predict on input transfers, check output transfers
  always @(posedge clk) begin
    grant_t got;
    grant_t want;
    if (rst) begin
      pool_base = '0;
      pool_size = POOL_MAX_BYTES;
      rebuild_table();
      grant_q.delete();
      errors  = 0;
      pending = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_BASE) begin
          pool_base = cfg_wdata;
        end else begin
          if (cfg_wdata < HEADER_BYTES + 1) pool_size = HEADER_BYTES + 1;
          else if (cfg_wdata > POOL_MAX_BYTES) pool_size = POOL_MAX_BYTES;
          else pool_size = cfg_wdata;
        end
        rebuild_table();
      end
      if (out_valid && !out_stall) begin
        got.status = status;
        got.addr   = alloc_addr;
        if (grant_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result status %0d addr %h", $realtime,
                     got.status, got.addr);
        end else begin
          want = grant_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("%0t: result mismatch: status exp %0d got %0d, addr exp %h got %h",
                       $realtime, want.status, got.status, want.addr, got.addr);
          end
        end
      end
      if (in_valid && !in_stall) begin
        want.addr = '0;
        if (cmd == CMD_ALLOC) want.status = grant_block(req_size, want.addr);
        else want.status = release_block(free_addr);
        if (want.status != ST_OK) want.addr = '0;
        grant_q.push_back(want);
      end
      pending = grant_q.size();
    end
  end

endmodule

// ===== tb/tb_first_fit_pool_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_pool_allocator
// Drives allocate and free requests through several pool settings: a short
// directed set of edge cases, then random traffic with idling on both sides,
// a long output hold and a full drain; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_first_fit_pool_allocator;
  import ffpa_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        cmd;
  logic [15:0] req_size;
  logic [31:0] free_addr;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [31:0] alloc_addr;
  int          errors;
  int          pending;

  bit          src_idle_on;
  bit          snk_idle_on;
  bit          hold_go;
  int          hold_left;
  int          quiet_cnt;
  logic [31:0] cur_base;
  logic [31:0] cur_pool;
  int          size_cap;
  logic [31:0] granted_q[$];
  bit          sent_cmd_q[$];

  first_fit_pool_allocator i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .req_size   (req_size),
    .free_addr  (free_addr),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .alloc_addr (alloc_addr)
  );

  ffpa_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .req_size   (req_size),
    .free_addr  (free_addr),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .alloc_addr (alloc_addr),
    .errors     (errors),
    .pending    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: random stall, or a long hold when asked
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_go && hold_left == 0) begin
      out_stall <= 1'b1;
      hold_left <= 400;
    end else if (hold_left > 0) begin
      out_stall <= (hold_left > 1);
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= snk_idle_on && ($urandom_range(99) < 19);
    end
  end

  // remember granted addresses so frees can name live blocks
  always @(posedge clk) begin
    bit c;
    if (!rst && out_valid && !out_stall && sent_cmd_q.size() > 0) begin
      c = sent_cmd_q.pop_front();
      if (c == CMD_ALLOC && status == ST_OK) granted_q.push_back(alloc_addr);
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= 20000) begin
      $display("tb_first_fit_pool_allocator: errors");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  // one request transfer
  task automatic send_req(input bit c, input logic [15:0] sz, input logic [31:0] a);
    if (src_idle_on && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    req_size  <= sz;
    free_addr <= a;
    do @(posedge clk); while (in_stall);
    sent_cmd_q.push_back(c);
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    repeat (4) @(posedge clk);
  endtask

  // new pool setting, table rebuilt
  task automatic set_pool(input logic [31:0] b, input logic [31:0] p);
    drain();
    write_reg(REG_BASE, b);
    write_reg(REG_POOL, p);
    cur_base = b;
    cur_pool = (p < 21) ? 32'd21 : (p > 65536) ? 32'd65536 : p;
    granted_q.delete();
  endtask

  // one random request: mostly allocations, then frees of live blocks and of stray addresses
  task automatic random_req();
    int          r;
    int          k;
    logic [15:0] sz;
    logic [31:0] a;
    r = $urandom_range(99);
    if (r < 52 || granted_q.size() == 0 && r < 80) begin
      if ($urandom_range(19) == 0) sz = 16'($urandom);
      else sz = 16'($urandom_range(0, size_cap));
      send_req(CMD_ALLOC, sz, 32'd0);
    end else if (r < 85 && granted_q.size() > 0) begin
      k = $urandom_range(0, granted_q.size() - 1);
      a = granted_q[k];
      granted_q.delete(k);
      send_req(CMD_FREE, 16'($urandom), a);
    end else begin
      case ($urandom_range(3))
        0: a = $urandom;
        1: a = cur_base + $urandom_range(0, cur_pool + 4);
        2: a = (granted_q.size() > 0) ? granted_q[0] + 1 : cur_base;
        default: a = cur_base + 20;
      endcase
      send_req(CMD_FREE, 16'($urandom), a);
    end
  endtask

  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = REG_BASE;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    cmd         = CMD_ALLOC;
    req_size    = '0;
    free_addr   = '0;
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    hold_go     = 1'b0;
    cur_base    = '0;
    cur_pool    = 32'd65536;
    size_cap    = 512;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset pool, edges of both operations
    send_req(CMD_ALLOC, 16'd0, '0);
    send_req(CMD_ALLOC, 16'hFFFF, '0);
    send_req(CMD_ALLOC, 16'd100, '0);
    send_req(CMD_FREE, 16'hFFFF, 32'd5);
    send_req(CMD_FREE, '0, 32'd65536);
    send_req(CMD_FREE, '0, 32'hFFFF_FFFF);
    send_req(CMD_FREE, '0, 32'd21);
    send_req(CMD_FREE, '0, 32'd20);
    send_req(CMD_FREE, '0, 32'd20);
    send_req(CMD_FREE, '0, 32'd40);
    send_req(CMD_ALLOC, 16'd65515, '0);
    send_req(CMD_FREE, '0, 32'd20);
    send_req(CMD_ALLOC, 16'd65516, '0);
    send_req(CMD_ALLOC, 16'd65475, '0);
    send_req(CMD_FREE, '0, 32'd20);
    drain();

    repeat (375) random_req();

    // smallest pool, top of the address space
    set_pool(32'hFFFF_FF00, 32'd0);
    size_cap = 4;
    repeat (60) random_req();

    // oversized pool value, tiny sizes fill the table
    set_pool(32'h1000_0000, 32'h0003_0000);
    size_cap = 8;
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    repeat (150) random_req();
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    in_valid <= 1'b0;
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    repeat (150) random_req();

    // random base, small pool
    set_pool($urandom, 32'd400);
    size_cap = 120;
    repeat (250) random_req();

    // base that wraps, full pool, a full drain midway
    set_pool(32'hFFFF_FFF0, 32'd65536);
    size_cap = 2000;
    repeat (150) random_req();
    drain();
    repeat (150) random_req();

    drain();
    if (errors == 0 && pending == 0) begin
      $display("tb_first_fit_pool_allocator: clean");
    end else begin
      $display("tb_first_fit_pool_allocator: errors");
    end
    $finish;
  end

endmodule
